FILE: rtl/ffa_pkg.sv
// Package for the first-fit chunk allocator: sizes, codes, table entry and
// handshake structs. Depends on nothing; used by ffa_ctrl and the top level.
package ffa_pkg;

  localparam int PAGE_BYTES  = 4096;
  localparam int MAX_PAGES   = 4;
  localparam int TABLE_DEPTH = 64;
  localparam int GRAIN_BYTES = 256;

  localparam int TYPE_W   = 2;
  localparam int RSIZE_W  = 16;
  localparam int ADDR_W   = 14;
  localparam int SIZE_W   = 13;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int PAGE_W   = $clog2(MAX_PAGES + 1);

  localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              head;
  } entry_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [RSIZE_W-1:0] size;
    logic [ADDR_W-1:0]  addr;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   grant;
  } rsp_t;

endpackage

FILE: rtl/ffa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/ffa_ctrl.sv
// Sequencer of the allocator: scans the chunk table, splits, merges and
// compacts it one entry per cycle. Depends on ffa_pkg and ffa_ram.
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ffa_pkg::req_t req_i,
  input  logic          rsp_ready_i,
  output logic          idle_o,
  output logic          done_o,
  output ffa_pkg::rsp_t rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FR_NEXT, S_FR_DEC, S_MOVE, S_WR_A, S_WR_B, S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic [ffa_pkg::CNT_W-1:0]   count_q, count_d, count_nxt_q, count_nxt_d;
  logic [ffa_pkg::PAGE_W-1:0]  pages_q, pages_d;
  ffa_pkg::req_t               req_q, req_d;
  logic [ffa_pkg::CNT_W-1:0]   scan_idx_q, scan_idx_d;
  logic                        chk_v_q, chk_v_d;
  logic [ffa_pkg::IDX_W-1:0]   chk_idx_q, chk_idx_d;
  ffa_pkg::entry_t             prev_q, prev_d, hit_q, hit_d;
  logic [ffa_pkg::IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic                        fol_v_q, fol_v_d;
  logic [ffa_pkg::IDX_W-1:0]   wa_idx_q, wa_idx_d, wb_idx_q, wb_idx_d;
  ffa_pkg::entry_t             wa_q, wa_d, wb_q, wb_d;
  logic                        wb_v_q, wb_v_d;
  logic [ffa_pkg::CNT_W-1:0]   mv_src_q, mv_src_d, mv_left_q, mv_left_d;
  logic                        mv_up_q, mv_up_d;
  logic [1:0]                  mv_k_q, mv_k_d;
  logic                        pend_v_q, pend_v_d;
  logic [ffa_pkg::CNT_W-1:0]   pend_src_q, pend_src_d;
  ffa_pkg::rsp_t               rsp_q, rsp_d;

  logic                        ram_we;
  logic [ffa_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
  ffa_pkg::entry_t             ram_wdata, ram_rdata;

  logic [ffa_pkg::SIZE_W-1:0]  rsz;
  logic                        room, match, mf, mp;
  logic [ffa_pkg::SIZE_W-1:0]  size_i, size_p;
  logic [ffa_pkg::ADDR_W-1:0]  page_start;
  logic [ffa_pkg::CNT_W-1:0]   need, src0, dst;
  ffa_pkg::entry_t             fol;

  ffa_ram #(
    .WIDTH($bits(ffa_pkg::entry_t)),
    .DEPTH(ffa_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign idle_o = (state_q == S_IDLE);
  assign rsp_o  = rsp_q;
  assign rsz    = req_q.size[ffa_pkg::SIZE_W-1:0];
  assign room   = count_q < ffa_pkg::CNT_W'(ffa_pkg::TABLE_DEPTH);
  assign page_start = ffa_pkg::ADDR_W'(pages_q) * ffa_pkg::ADDR_W'(ffa_pkg::PAGE_BYTES);
  assign fol    = ram_rdata;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    count_nxt_d = count_nxt_q;
    pages_d     = pages_q;
    req_d       = req_q;
    scan_idx_d  = scan_idx_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    prev_d      = prev_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    fol_v_d     = fol_v_q;
    wa_idx_d    = wa_idx_q;
    wa_d        = wa_q;
    wb_idx_d    = wb_idx_q;
    wb_d        = wb_q;
    wb_v_d      = wb_v_q;
    mv_src_d    = mv_src_q;
    mv_left_d   = mv_left_q;
    mv_up_d     = mv_up_q;
    mv_k_d      = mv_k_q;
    pend_v_d    = pend_v_q;
    pend_src_d  = pend_src_q;
    rsp_d       = rsp_q;
    done_o      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = wa_idx_q;
    ram_wdata   = wa_q;
    ram_raddr   = scan_idx_q[ffa_pkg::IDX_W-1:0];
    match       = 1'b0;
    mf          = 1'b0;
    mp          = 1'b0;
    size_i      = '0;
    size_p      = '0;
    need        = '0;
    src0        = '0;
    dst         = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d       = req_i;
          rsp_d       = '{status: ffa_pkg::ST_OK, grant: '0};
          count_nxt_d = count_q;
          scan_idx_d  = '0;
          chk_v_d     = 1'b0;
          wb_v_d      = 1'b0;
          mv_left_d   = '0;
          pend_v_d    = 1'b0;
          state_d     = S_DONE;
          case (req_i.kind)
            ffa_pkg::REQ_ALLOC: begin
              if (req_i.size == '0
                  || (req_i.size % ffa_pkg::RSIZE_W'(ffa_pkg::GRAIN_BYTES)) != '0
                  || req_i.size > ffa_pkg::RSIZE_W'(ffa_pkg::PAGE_BYTES)) begin
                rsp_d.status = ffa_pkg::ST_BAD_SIZE;
              end else begin
                state_d = S_SCAN;
              end
            end
            ffa_pkg::REQ_FREE: begin
              state_d = S_SCAN;
            end
            ffa_pkg::REQ_CLEAR: begin
              count_d     = '0;
              count_nxt_d = '0;
              pages_d     = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_idx_q < count_q) begin
          scan_idx_d = scan_idx_q + 1'b1;
          chk_v_d    = 1'b1;
          chk_idx_d  = scan_idx_q[ffa_pkg::IDX_W-1:0];
        end else begin
          chk_v_d = 1'b0;
        end
        if (chk_v_q) begin
          if (req_q.kind == ffa_pkg::REQ_ALLOC) begin
            match = ram_rdata.free && (ram_rdata.size == rsz
                    || (ram_rdata.size > rsz && room));
          end else begin
            match = ram_rdata.start == req_q.addr;
          end
          prev_d = ram_rdata;
        end
        if (match) begin
          chk_v_d   = 1'b0;
          hit_d     = ram_rdata;
          hit_idx_d = chk_idx_q;
          prev_d    = prev_q;
          if (req_q.kind == ffa_pkg::REQ_ALLOC) begin
            rsp_d.grant = ram_rdata.start;
            if (ram_rdata.size > rsz) begin
              wa_idx_d    = chk_idx_q + 1'b1;
              wa_d        = '{free: 1'b1, start: ram_rdata.start + ffa_pkg::ADDR_W'(rsz),
                              size: ram_rdata.size - rsz, head: 1'b0};
              wb_idx_d    = chk_idx_q;
              wb_d        = '{free: 1'b0, start: ram_rdata.start, size: rsz,
                              head: ram_rdata.head};
              wb_v_d      = 1'b1;
              mv_up_d     = 1'b1;
              mv_k_d      = 2'd1;
              mv_src_d    = count_q - 1'b1;
              mv_left_d   = count_q - 1'b1 - ffa_pkg::CNT_W'(chk_idx_q);
              count_nxt_d = count_q + 1'b1;
              state_d     = S_MOVE;
            end else begin
              wa_idx_d = chk_idx_q;
              wa_d     = ram_rdata;
              wa_d.free = 1'b0;
              state_d  = S_WR_A;
            end
          end else if (ffa_pkg::CNT_W'(chk_idx_q) + 1'b1 < count_q) begin
            state_d = S_FR_NEXT;
          end else begin
            fol_v_d = 1'b0;
            state_d = S_FR_DEC;
          end
        end else if (!chk_v_q && scan_idx_q >= count_q) begin
          state_d = S_DONE;
          if (req_q.kind == ffa_pkg::REQ_FREE) begin
            rsp_d.status = ffa_pkg::ST_NOT_FOUND;
          end else begin
            need = (rsz < ffa_pkg::SIZE_W'(ffa_pkg::PAGE_BYTES))
                   ? ffa_pkg::CNT_W'(2) : ffa_pkg::CNT_W'(1);
            if (pages_q >= ffa_pkg::PAGE_W'(ffa_pkg::MAX_PAGES)
                || count_q + need > ffa_pkg::CNT_W'(ffa_pkg::TABLE_DEPTH)) begin
              rsp_d.status = ffa_pkg::ST_NO_SPACE;
            end else begin
              rsp_d.grant = page_start;
              pages_d     = pages_q + 1'b1;
              wa_idx_d    = count_q[ffa_pkg::IDX_W-1:0];
              wa_d        = '{free: 1'b0, start: page_start, size: rsz, head: 1'b1};
              wb_idx_d    = wa_idx_d + 1'b1;
              wb_d        = '{free: 1'b1, start: page_start + ffa_pkg::ADDR_W'(rsz),
                              size: ffa_pkg::SIZE_W'(ffa_pkg::PAGE_BYTES) - rsz,
                              head: 1'b0};
              wb_v_d      = (need == ffa_pkg::CNT_W'(2));
              count_nxt_d = count_q + need;
              state_d     = S_WR_A;
            end
          end
        end
      end

      S_FR_NEXT: begin
        ram_raddr = hit_idx_q + 1'b1;
        fol_v_d   = 1'b1;
        state_d   = S_FR_DEC;
      end

      S_FR_DEC: begin
        mf     = fol_v_q && fol.free && !fol.head;
        mp     = (hit_idx_q != '0) && !hit_q.head && prev_q.free;
        size_i = hit_q.size + (mf ? fol.size : '0);
        size_p = prev_q.size + size_i;
        mv_up_d = 1'b0;
        if (mp) begin
          wa_idx_d = hit_idx_q - 1'b1;
          wa_d     = '{free: 1'b1, start: prev_q.start, size: size_p, head: prev_q.head};
          mv_k_d   = mf ? 2'd2 : 2'd1;
        end else begin
          wa_idx_d = hit_idx_q;
          wa_d     = '{free: 1'b1, start: hit_q.start, size: size_i, head: hit_q.head};
          mv_k_d   = mf ? 2'd1 : 2'd0;
        end
        src0 = ffa_pkg::CNT_W'(hit_idx_q) + 1'b1 + (mf ? 1'b1 : 1'b0);
        mv_src_d    = src0;
        mv_left_d   = (mv_k_d != 2'd0 && src0 < count_q) ? count_q - src0 : '0;
        count_nxt_d = count_q - ffa_pkg::CNT_W'(mv_k_d);
        state_d     = S_MOVE;
      end

      S_MOVE: begin
        ram_raddr = mv_src_q[ffa_pkg::IDX_W-1:0];
        if (mv_left_q != '0) begin
          mv_src_d   = mv_up_q ? mv_src_q - 1'b1 : mv_src_q + 1'b1;
          mv_left_d  = mv_left_q - 1'b1;
          pend_v_d   = 1'b1;
          pend_src_d = mv_src_q;
        end else begin
          pend_v_d = 1'b0;
        end
        dst = mv_up_q ? pend_src_q + 1'b1 : pend_src_q - ffa_pkg::CNT_W'(mv_k_q);
        if (pend_v_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst[ffa_pkg::IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (mv_left_q == '0 && !pend_v_q) begin
          state_d = S_WR_A;
        end
      end

      S_WR_A: begin
        ram_we  = 1'b1;
        state_d = wb_v_q ? S_WR_B : S_DONE;
      end

      S_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = wb_idx_q;
        ram_wdata = wb_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        count_d = count_nxt_q;
        if (rsp_ready_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pages_q  <= '0;
      chk_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pages_q  <= pages_d;
      chk_v_q  <= chk_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_nxt_q <= count_nxt_d;
    req_q       <= req_d;
    scan_idx_q  <= scan_idx_d;
    chk_idx_q   <= chk_idx_d;
    prev_q      <= prev_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    fol_v_q     <= fol_v_d;
    wa_idx_q    <= wa_idx_d;
    wa_q        <= wa_d;
    wb_idx_q    <= wb_idx_d;
    wb_q        <= wb_d;
    wb_v_q      <= wb_v_d;
    mv_src_q    <= mv_src_d;
    mv_left_q   <= mv_left_d;
    mv_up_q     <= mv_up_d;
    mv_k_q      <= mv_k_d;
    pend_src_q  <= pend_src_d;
    rsp_q       <= rsp_d;
  end

endmodule

FILE: rtl/first_fit_chunk_allocator_top.sv
// Top level of the first-fit chunk allocator: request and result channels
// and the result register. Depends on ffa_pkg and ffa_ctrl.
//
// A request word (req_type_i, req_size_i, req_addr_i) is taken when
// in_valid_i and in_ready_o are both high. Allocate, free and clear each
// produce exactly one result word (status_o, grant_addr_o), offered with
// out_valid_o and taken when out_ready_i is high.
// The block works on one request at a time and is not ready meanwhile.
// Allocate scans the chunk table at one entry per cycle and a split then
// shifts the entries above the chosen one up by one, again one per cycle;
// free scans likewise and compacts the table after a merge. The table RAM
// read and write port sets that rate.
// A result waits in its register while the receiver stalls; the next
// request is still taken, and finishes once that register is free.
// Reset empties the table and closes all pages at once; no clearing pass
// is needed, since only entries below the entry count are read.
module first_fit_chunk_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ffa_pkg::TYPE_W-1:0]    req_type_i,
  input  logic [ffa_pkg::RSIZE_W-1:0]   req_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0]    req_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffa_pkg::STATUS_W-1:0]  status_o,
  output logic [ffa_pkg::ADDR_W-1:0]    grant_addr_o
);

  ffa_pkg::req_t req;
  ffa_pkg::rsp_t rsp;
  logic          idle, done, rsp_ready;
  logic          out_valid_q;
  ffa_pkg::rsp_t out_q;

  assign req        = '{kind: req_type_i, size: req_size_i, addr: req_addr_i};
  assign rsp_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = idle;

  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && idle),
    .req_i      (req),
    .rsp_ready_i(rsp_ready),
    .idle_o     (idle),
    .done_o     (done),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign grant_addr_o = out_q.grant;

endmodule
